>>> src/rbnh_pkg.sv
// Shared types, constants and arithmetic helpers for the ray / box nearest-hit block.
package rbnh_pkg;

	localparam int VAL_W     = 32;
	localparam int FRAC_BITS = 16;
	localparam int ID_BITS   = 16;
	localparam int ID_W      = 16;
	localparam int DIST_W    = VAL_W - 1;
	localparam int NUM_AXES  = 3;

	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic signed [2*VAL_W-1:0] prod_t;
	typedef val_t [NUM_AXES-1:0]       vec3_t;
	typedef logic [ID_BITS-1:0]        id_t;

	localparam val_t MAXV = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t MINV = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [2:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_ORIGIN_Z  = 3'd2,
		CFG_INV_DIR_X = 3'd3,
		CFG_INV_DIR_Y = 3'd4,
		CFG_INV_DIR_Z = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic last_box;
		id_t  id;
	} tag_t;

	function automatic val_t sat_diff(val_t a, val_t b);
		logic signed [VAL_W:0] d;
		d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		if (d[VAL_W] != d[VAL_W-1]) begin
			return d[VAL_W] ? MINV : MAXV;
		end
		return d[VAL_W-1:0];
	endfunction

	// Floor shift by the fraction width, then saturate to the value range.
	function automatic val_t scale_sat(prod_t p);
		prod_t s;
		s = p >>> FRAC_BITS;
		if (s[2*VAL_W-1:VAL_W-1] != {(VAL_W+1){s[2*VAL_W-1]}}) begin
			return s[2*VAL_W-1] ? MINV : MAXV;
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic val_t max2(val_t a, val_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic val_t min2(val_t a, val_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

>>> src/rbnh_if.sv
// Handshake channel interfaces for boxes, hit results and configuration writes.
interface rbnh_box_if;
	logic          valid;
	logic          ready;
	rbnh_pkg::val_t box_min_x;
	rbnh_pkg::val_t box_min_y;
	rbnh_pkg::val_t box_min_z;
	rbnh_pkg::val_t box_max_x;
	rbnh_pkg::val_t box_max_y;
	rbnh_pkg::val_t box_max_z;
	logic [15:0]   object_id;
	logic          last_box;

	modport source(output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, object_id, last_box, input ready);
	modport sink(input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, object_id, last_box, output ready);
endinterface

interface rbnh_hit_if;
	logic        valid;
	logic        ready;
	logic        hit_found;
	logic [15:0] hit_id;
	logic [30:0] hit_distance;

	modport source(output valid, hit_found, hit_id, hit_distance, input ready);
	modport sink(input valid, hit_found, hit_id, hit_distance, output ready);
endinterface

interface rbnh_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> src/rbnh_slab.sv
// One axis of the slab test: offset, scaled multiply and ordering of the two distances.
module rbnh_slab (
	input  logic           clk,
	input  logic           adv,
	input  rbnh_pkg::val_t box_lo,
	input  rbnh_pkg::val_t box_hi,
	input  rbnh_pkg::val_t origin,
	input  rbnh_pkg::val_t inv_dir,
	output rbnh_pkg::val_t t_near_s4,
	output rbnh_pkg::val_t t_far_s4
);

	rbnh_pkg::val_t  lo_s2;
	rbnh_pkg::val_t  hi_s2;
	rbnh_pkg::prod_t prod_lo_s3;
	rbnh_pkg::prod_t prod_hi_s3;
	rbnh_pkg::val_t  t_lo;
	rbnh_pkg::val_t  t_hi;

	assign t_lo = rbnh_pkg::scale_sat(prod_lo_s3);
	assign t_hi = rbnh_pkg::scale_sat(prod_hi_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s2      <= rbnh_pkg::sat_diff(box_lo, origin);
			hi_s2      <= rbnh_pkg::sat_diff(box_hi, origin);
			prod_lo_s3 <= lo_s2 * inv_dir;
			prod_hi_s3 <= hi_s2 * inv_dir;
			t_near_s4  <= rbnh_pkg::min2(t_lo, t_hi);
			t_far_s4   <= rbnh_pkg::max2(t_lo, t_hi);
		end
	end

endmodule

>>> src/rbnh_nearest.sv
// Entry / exit fold, nearest-hit accumulator and result register.
module rbnh_nearest (
	input  logic              clk,
	input  logic              arst_n,
	input  rbnh_pkg::tag_t    tag_s4,
	input  rbnh_pkg::vec3_t   near_s4,
	input  rbnh_pkg::vec3_t   far_s4,
	output logic              stall,
	rbnh_hit_if.source        hit
);

	rbnh_pkg::tag_t tag_s5;
	rbnh_pkg::val_t enter_s5;
	rbnh_pkg::val_t leave_s5;

	rbnh_pkg::val_t near_dist_q;
	rbnh_pkg::id_t  near_id_q;
	logic           any_hit_q;

	logic           out_valid_q;
	logic           out_found_q;
	logic [15:0]    out_id_q;
	logic [30:0]    out_dist_q;

	logic           adv;
	logic           take;
	logic           hit_c;
	logic           better_c;
	rbnh_pkg::val_t d_c;
	rbnh_pkg::val_t dist_n;
	rbnh_pkg::id_t  id_n;
	logic           any_n;

	assign stall = out_valid_q && !hit.ready && tag_s5.valid && tag_s5.last_box;
	assign adv   = !stall;
	assign take  = adv && tag_s5.valid;

	assign hit_c    = (enter_s5 <= leave_s5) && !leave_s5[rbnh_pkg::VAL_W-1];
	assign d_c      = enter_s5[rbnh_pkg::VAL_W-1] ? leave_s5 : enter_s5;
	assign better_c = hit_c && (d_c < near_dist_q);
	assign any_n    = any_hit_q || better_c;
	assign dist_n   = better_c ? d_c : near_dist_q;
	assign id_n     = better_c ? tag_s5.id : near_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else if (adv) begin
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			enter_s5 <= rbnh_pkg::max2(rbnh_pkg::max2(near_s4[0], near_s4[1]), near_s4[2]);
			leave_s5 <= rbnh_pkg::min2(rbnh_pkg::min2(far_s4[0], far_s4[1]), far_s4[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_dist_q <= rbnh_pkg::MAXV;
			near_id_q   <= '0;
			any_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (hit.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (tag_s5.last_box) begin
					near_dist_q <= rbnh_pkg::MAXV;
					near_id_q   <= '0;
					any_hit_q   <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					near_dist_q <= dist_n;
					near_id_q   <= id_n;
					any_hit_q   <= any_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && tag_s5.last_box) begin
			out_found_q <= any_n;
			out_id_q    <= any_n ? 16'(id_n) : '0;
			out_dist_q  <= any_n ? dist_n[rbnh_pkg::DIST_W-1:0] : '1;
		end
	end

	assign hit.valid        = out_valid_q;
	assign hit.hit_found    = out_found_q;
	assign hit.hit_id       = out_id_q;
	assign hit.hit_distance = out_dist_q;

	a_empty_state: assert property (@(posedge clk) disable iff (!arst_n)
		!any_hit_q |-> (near_dist_q == rbnh_pkg::MAXV) && (near_id_q == '0))
		else $error("nearest state holds data without a hit");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit_q |-> !near_dist_q[rbnh_pkg::VAL_W-1] && (near_dist_q != rbnh_pkg::MAXV))
		else $error("kept hit distance out of range");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tag_s5.last_box) |=> !any_hit_q && out_valid_q)
		else $error("list end did not clear state or post a result");

	a_miss_result: assert property (@(posedge clk) disable iff (!arst_n)
		(hit.valid && !hit.hit_found) |-> (hit.hit_id == '0) && (hit.hit_distance == '1))
		else $error("miss result carries hit data");

endmodule

>>> src/ray_box_nearest_hit.sv
// Top level: ray registers, box input register, three slab lanes and nearest-hit stage.
//
//  channel  dir  beat contents
//  cfg      in   index (0..5), data: ray origin xyz, reciprocal direction xyz
//  box      in   box_min_xyz, box_max_xyz, object_id, last_box
//  hit      out  hit_found, hit_id, hit_distance (one beat per last_box)
//
// One box a cycle unless stalled; the result register loads when a list's last box is accumulated.
// Stages: input register, offset, multiply, scale and order, entry/exit fold, accumulate.
// The per-cycle rate is held by the nearest-distance compare in the accumulate stage.
// Reset loads origin zero, reciprocal direction at format maximum and clears the nearest hit.
// The pipe stalls only when a finished list meets a result beat not yet taken.
module ray_box_nearest_hit (
	input  logic       clk,
	input  logic       arst_n,
	rbnh_cfg_if.sink   cfg,
	rbnh_box_if.sink   box,
	rbnh_hit_if.source hit
);

	rbnh_pkg::vec3_t org_q;
	rbnh_pkg::vec3_t inv_q;

	rbnh_pkg::vec3_t box_lo_s1;
	rbnh_pkg::vec3_t box_hi_s1;
	rbnh_pkg::tag_t  tag_s1;
	rbnh_pkg::tag_t  tag_s2;
	rbnh_pkg::tag_t  tag_s3;
	rbnh_pkg::tag_t  tag_s4;
	rbnh_pkg::vec3_t near_s4;
	rbnh_pkg::vec3_t far_s4;

	logic stall;
	logic adv;

	assign adv       = !stall;
	assign box.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
			inv_q <= {rbnh_pkg::NUM_AXES{rbnh_pkg::MAXV}};
		end else if (cfg.valid) begin
			case (rbnh_pkg::cfg_idx_t'(cfg.index))
				rbnh_pkg::CFG_ORIGIN_X:  org_q[0] <= cfg.data;
				rbnh_pkg::CFG_ORIGIN_Y:  org_q[1] <= cfg.data;
				rbnh_pkg::CFG_ORIGIN_Z:  org_q[2] <= cfg.data;
				rbnh_pkg::CFG_INV_DIR_X: inv_q[0] <= cfg.data;
				rbnh_pkg::CFG_INV_DIR_Y: inv_q[1] <= cfg.data;
				rbnh_pkg::CFG_INV_DIR_Z: inv_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s1.valid    <= box.valid;
			tag_s1.last_box <= box.last_box;
			tag_s1.id       <= rbnh_pkg::id_t'(box.object_id);
			tag_s2          <= tag_s1;
			tag_s3          <= tag_s2;
			tag_s4          <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_lo_s1 <= {box.box_min_z, box.box_min_y, box.box_min_x};
			box_hi_s1 <= {box.box_max_z, box.box_max_y, box.box_max_x};
		end
	end

	for (genvar a = 0; a < rbnh_pkg::NUM_AXES; a++) begin : g_axis
		rbnh_slab u_slab (
			.clk       (clk),
			.adv       (adv),
			.box_lo    (box_lo_s1[a]),
			.box_hi    (box_hi_s1[a]),
			.origin    (org_q[a]),
			.inv_dir   (inv_q[a]),
			.t_near_s4 (near_s4[a]),
			.t_far_s4  (far_s4[a])
		);
	end

	rbnh_nearest u_nearest (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s4  (tag_s4),
		.near_s4 (near_s4),
		.far_s4  (far_s4),
		.stall   (stall),
		.hit     (hit)
	);

endmodule

>>> dv/ray_box_nearest_hit_tb.sv
// Testbench for ray_box_nearest_hit: directed box table, then random ray phases checked beat by beat.
`timescale 1ns / 1ps

module ray_box_nearest_hit_tb;

	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_BOXES   = 1430;
	localparam int PHASES         = 10;
	localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
	localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
	localparam logic [30:0] NO_HIT_DIST = '1;
	localparam rbnh_pkg::val_t ONE = 32'sd65536;

	typedef struct packed {
		rbnh_pkg::vec3_t lo;
		rbnh_pkg::vec3_t hi;
		logic [15:0]     id;
		logic            last;
	} box_beat_t;

	typedef struct packed {
		logic        found;
		logic [15:0] id;
		logic [30:0] distance;
	} hit_t;

	typedef struct {
		logic           is_cfg;
		logic [2:0]     reg_index;
		rbnh_pkg::val_t reg_data;
		box_beat_t      beat;
		logic           typed;
		hit_t           want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rbnh_cfg_if cfg_ch();
	rbnh_box_if box_ch();
	rbnh_hit_if hit_ch();

	ray_box_nearest_hit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.box(box_ch),
		.hit(hit_ch)
	);

	always #5 clk = ~clk;

	rbnh_pkg::val_t ray_org[3];
	rbnh_pkg::val_t ray_inv[3];
	longint         nearest_dist;
	logic [15:0]    nearest_id;
	logic           nearest_valid;
	hit_t           pending_hits[$];
	int             failures = 0;
	bit             burst = 1'b0;
	bit             no_gaps = 1'b0;
	int             hold_asks = 0;

	function automatic rbnh_pkg::val_t slab_dist(rbnh_pkg::val_t corner, rbnh_pkg::val_t org,
		rbnh_pkg::val_t inv);
		longint off;
		longint t;
		off = longint'(corner) - longint'(org);
		if (off > longint'(rbnh_pkg::MAXV)) off = longint'(rbnh_pkg::MAXV);
		if (off < longint'(rbnh_pkg::MINV)) off = longint'(rbnh_pkg::MINV);
		t = (off * longint'(inv)) >>> rbnh_pkg::FRAC_BITS;
		if (t > longint'(rbnh_pkg::MAXV)) t = longint'(rbnh_pkg::MAXV);
		if (t < longint'(rbnh_pkg::MINV)) t = longint'(rbnh_pkg::MINV);
		return rbnh_pkg::val_t'(t);
	endfunction

	function automatic logic fold_box_into_nearest(box_beat_t b, output hit_t res);
		longint entry;
		longint leave;
		longint t1;
		longint t2;
		longint d;
		entry = rbnh_pkg::MINV;
		leave = rbnh_pkg::MAXV;
		for (int a = 0; a < rbnh_pkg::NUM_AXES; a++) begin
			t1 = slab_dist(b.lo[a], ray_org[a], ray_inv[a]);
			t2 = slab_dist(b.hi[a], ray_org[a], ray_inv[a]);
			if (t1 > t2) begin
				d = t1;
				t1 = t2;
				t2 = d;
			end
			if (t1 > entry) entry = t1;
			if (t2 < leave) leave = t2;
		end
		if (entry <= leave && leave >= 0) begin
			d = (entry >= 0) ? entry : leave;
			if (d < nearest_dist) begin
				nearest_dist = d;
				nearest_id = b.id;
				nearest_valid = 1'b1;
			end
		end
		res = '0;
		if (!b.last) return 1'b0;
		res.found = nearest_valid;
		res.id = nearest_valid ? nearest_id : 16'd0;
		res.distance = nearest_valid ? nearest_dist[30:0] : NO_HIT_DIST;
		nearest_dist = rbnh_pkg::MAXV;
		nearest_id = '0;
		nearest_valid = 1'b0;
		return 1'b1;
	endfunction

	function automatic stim_row_t box_row(rbnh_pkg::val_t lo_x, rbnh_pkg::val_t lo_y,
		rbnh_pkg::val_t lo_z, rbnh_pkg::val_t hi_x, rbnh_pkg::val_t hi_y,
		rbnh_pkg::val_t hi_z, logic [15:0] id, logic last);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.reg_index = '0;
		r.reg_data = '0;
		r.beat.lo = {lo_z, lo_y, lo_x};
		r.beat.hi = {hi_z, hi_y, hi_x};
		r.beat.id = id;
		r.beat.last = last;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(stim_row_t r, logic found, logic [15:0] id,
		logic [30:0] hit_dist);
		r.typed = 1'b1;
		r.want.found = found;
		r.want.id = id;
		r.want.distance = hit_dist;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [2:0] idx, rbnh_pkg::val_t data);
		stim_row_t r;
		r = box_row(0, 0, 0, 0, 0, 0, 16'd0, 1'b0);
		r.is_cfg = 1'b1;
		r.reg_index = idx;
		r.reg_data = data;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rbnh_pkg::val_t clamp_word(longint v);
		if (v > longint'(rbnh_pkg::MAXV)) return rbnh_pkg::MAXV;
		if (v < longint'(rbnh_pkg::MINV)) return rbnh_pkg::MINV;
		return rbnh_pkg::val_t'(v);
	endfunction

	function automatic rbnh_pkg::val_t rand_origin();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return rbnh_pkg::val_t'(longint'($urandom_range(0, 2097152)) - 1048576);
	endfunction

	function automatic rbnh_pkg::val_t rand_inv();
		int r;
		longint m;
		r = $urandom_range(0, 99);
		if (r < 10) return rbnh_pkg::MAXV;
		if (r < 13) return rbnh_pkg::MINV;
		if (r < 20) return $urandom;
		m = $urandom_range(8192, 524288);
		return $urandom_range(0, 1) ? rbnh_pkg::val_t'(-m) : rbnh_pkg::val_t'(m);
	endfunction

	// Place a box around a point on the ray so most boxes are hit at varied distances.
	function automatic box_beat_t near_ray_box();
		box_beat_t b;
		longint t;
		longint dir;
		longint c;
		longint half;
		longint jit;
		t = longint'($urandom_range(0, 55 << 16)) - (5 << 16);
		for (int a = 0; a < rbnh_pkg::NUM_AXES; a++) begin
			dir = (ray_inv[a] == 0) ? 0 : (longint'(1) << 32) / longint'(ray_inv[a]);
			c = longint'(ray_org[a]) + ((t * dir) >>> rbnh_pkg::FRAC_BITS);
			half = $urandom_range(1, 4 << 16);
			jit = longint'($urandom_range(0, 4 << 16)) - (2 << 16);
			b.lo[a] = clamp_word(c - half + jit);
			b.hi[a] = clamp_word(c + half + jit);
		end
		b.id = $urandom_range(0, 65535);
		b.last = 1'b0;
		return b;
	endfunction

	function automatic box_beat_t draw_box();
		box_beat_t b;
		rbnh_pkg::val_t tmp;
		int r;
		r = $urandom_range(0, 99);
		b = near_ray_box();
		if (r < 60) return b;
		for (int a = 0; a < rbnh_pkg::NUM_AXES; a++) begin
			if (r < 75) begin
				if ($urandom_range(0, 1)) begin
					tmp = b.lo[a];
					b.lo[a] = b.hi[a];
					b.hi[a] = tmp;
				end
			end else if (r < 90) begin
				b.lo[a] = rbnh_pkg::val_t'(longint'($urandom_range(0, 128 << 16)) - (64 << 16));
				b.hi[a] = clamp_word(longint'(rbnh_pkg::val_t'(b.lo[a])) +
					$urandom_range(0, 16 << 16));
			end else begin
				b.lo[a] = $urandom;
				b.hi[a] = $urandom;
			end
		end
		return b;
	endfunction

	function automatic int pick_list_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 1;
		if (r < 95) return $urandom_range(2, 12);
		return $urandom_range(30, 60);
	endfunction

	task automatic send_box(box_beat_t b, logic typed, hit_t want);
		int gap;
		hit_t res;
		gap = no_gaps ? 0 : gap_len();
		if (gap > 0) begin
			box_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.box_min_x <= b.lo[0];
		box_ch.box_min_y <= b.lo[1];
		box_ch.box_min_z <= b.lo[2];
		box_ch.box_max_x <= b.hi[0];
		box_ch.box_max_y <= b.hi[1];
		box_ch.box_max_z <= b.hi[2];
		box_ch.object_id <= b.id;
		box_ch.last_box <= b.last;
		do @(posedge clk); while (!box_ch.ready);
		if (fold_box_into_nearest(b, res)) pending_hits.push_back(typed ? want : res);
	endtask

	task automatic write_reg(logic [2:0] idx, rbnh_pkg::val_t data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			rbnh_pkg::CFG_ORIGIN_X:  ray_org[0] = data;
			rbnh_pkg::CFG_ORIGIN_Y:  ray_org[1] = data;
			rbnh_pkg::CFG_ORIGIN_Z:  ray_org[2] = data;
			rbnh_pkg::CFG_INV_DIR_X: ray_inv[0] = data;
			rbnh_pkg::CFG_INV_DIR_Y: ray_inv[1] = data;
			rbnh_pkg::CFG_INV_DIR_Z: ray_inv[2] = data;
			default: ;
		endcase
	endtask

	// Hold until every result is back and the pipe has drained.
	task automatic settle();
		box_ch.valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_ray(int phase);
		rbnh_pkg::val_t org[3];
		rbnh_pkg::val_t inv[3];
		for (int a = 0; a < rbnh_pkg::NUM_AXES; a++) begin
			org[a] = rand_origin();
			inv[a] = rand_inv();
		end
		if (phase == 0) begin
			org = '{rbnh_pkg::MINV, rbnh_pkg::MAXV, 0};
			inv = '{rbnh_pkg::MAXV, rbnh_pkg::MINV, ONE};
		end else if (phase == 1) begin
			org = '{rbnh_pkg::MAXV, rbnh_pkg::MINV, rbnh_pkg::MAXV};
			inv = '{rbnh_pkg::MINV, rbnh_pkg::MAXV, -ONE};
		end
		write_reg(rbnh_pkg::CFG_ORIGIN_X, org[0]);
		write_reg(rbnh_pkg::CFG_ORIGIN_Y, org[1]);
		write_reg(rbnh_pkg::CFG_ORIGIN_Z, org[2]);
		write_reg(rbnh_pkg::CFG_INV_DIR_X, inv[0]);
		write_reg(rbnh_pkg::CFG_INV_DIR_Y, inv[1]);
		write_reg(rbnh_pkg::CFG_INV_DIR_Z, inv[2]);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, $urandom);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_list(int len, inout int sent);
		box_beat_t b;
		if ($urandom_range(0, 7) == 0) burst = !burst;
		for (int k = 0; k < len; k++) begin
			b = draw_box();
			b.last = (k == len - 1);
			send_box(b, 1'b0, '0);
			sent++;
		end
	endtask

	initial begin
		int hold_left;
		int stall_left;
		int hold_seen;
		logic nxt;
		hit_t exp_hit;
		hold_left = 0;
		stall_left = 0;
		hold_seen = 0;
		hit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hit_ch.valid && hit_ch.ready) begin
				if (pending_hits.size() == 0) begin
					$error("hit beat with no result pending");
					failures++;
				end else begin
					exp_hit = pending_hits.pop_front();
					if (hit_ch.hit_found !== exp_hit.found) begin
						$error("hit_found: expected %0d, got %0d", exp_hit.found,
							hit_ch.hit_found);
						failures++;
					end
					if (hit_ch.hit_id !== exp_hit.id) begin
						$error("hit_id: expected %0h, got %0h", exp_hit.id, hit_ch.hit_id);
						failures++;
					end
					if (hit_ch.hit_distance !== exp_hit.distance) begin
						$error("hit_distance: expected %0h, got %0h", exp_hit.distance,
							hit_ch.hit_distance);
						failures++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b0;
			end else if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES - 1;
				nxt = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt = 1'b0;
			end else begin
				stall_left = ($urandom_range(0, 99) < 30) ? gap_len() : 0;
				nxt = (stall_left == 0);
			end
			hit_ch.ready <= nxt;
		end
	end

	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((box_ch.valid && box_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		stim_row_t plan[$];
		logic prev_box;
		int sent;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		box_ch.valid <= 1'b0;
		box_ch.box_min_x <= '0;
		box_ch.box_min_y <= '0;
		box_ch.box_min_z <= '0;
		box_ch.box_max_x <= '0;
		box_ch.box_max_y <= '0;
		box_ch.box_max_z <= '0;
		box_ch.object_id <= '0;
		box_ch.last_box <= 1'b0;
		for (int a = 0; a < rbnh_pkg::NUM_AXES; a++) begin
			ray_org[a] = 0;
			ray_inv[a] = rbnh_pkg::MAXV;
		end
		nearest_dist = rbnh_pkg::MAXV;
		nearest_id = '0;
		nearest_valid = 1'b0;

		plan.push_back(typed_row(box_row(0, 0, 0, 0, 0, 0, 16'h0001, 1'b1),
			1'b1, 16'h0001, 31'd0));
		plan.push_back(typed_row(box_row(rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV,
			rbnh_pkg::MAXV, rbnh_pkg::MAXV, rbnh_pkg::MAXV, 16'hFFFF, 1'b1),
			1'b0, 16'h0000, NO_HIT_DIST));
		plan.push_back(typed_row(box_row(rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV,
			rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV, 16'hAAAA, 1'b1),
			1'b0, 16'h0000, NO_HIT_DIST));
		plan.push_back(box_row(0, 0, 0, 0, 0, 0, 16'h0005, 1'b0));
		plan.push_back(typed_row(box_row(0, 0, 0, 0, 0, 0, 16'h0009, 1'b1),
			1'b1, 16'h0005, 31'd0));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_X, -4 * ONE));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Y, ONE / 2));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_X, ONE));
		plan.push_back(box_row(10 * ONE, 0, -ONE, 12 * ONE, ONE, ONE, 16'h0100, 1'b0));
		plan.push_back(box_row(2 * ONE, 0, -ONE, 3 * ONE, ONE, ONE, 16'h0200, 1'b0));
		plan.push_back(box_row(3 * ONE, 0, -ONE, 2 * ONE, ONE, ONE, 16'h0300, 1'b0));
		plan.push_back(box_row(-5 * ONE, 0, -ONE, -3 * ONE, ONE, ONE, 16'h0400, 1'b0));
		plan.push_back(box_row(2 * ONE, 2 * ONE, -ONE, 3 * ONE, 3 * ONE, ONE, 16'h0500, 1'b1));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_X, rbnh_pkg::MINV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Y, rbnh_pkg::MINV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Z, rbnh_pkg::MINV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_X, rbnh_pkg::MAXV));
		plan.push_back(box_row(rbnh_pkg::MAXV, rbnh_pkg::MAXV, rbnh_pkg::MAXV,
			rbnh_pkg::MAXV, rbnh_pkg::MAXV, rbnh_pkg::MAXV, 16'h0600, 1'b1));
		plan.push_back(box_row(rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV,
			rbnh_pkg::MAXV, rbnh_pkg::MAXV, rbnh_pkg::MAXV, 16'h0700, 1'b1));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_X, rbnh_pkg::MAXV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Y, rbnh_pkg::MAXV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Z, rbnh_pkg::MAXV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_X, rbnh_pkg::MINV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_Y, rbnh_pkg::MINV));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_Z, rbnh_pkg::MINV));
		plan.push_back(box_row(rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV,
			rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV, 16'h0800, 1'b1));
		plan.push_back(box_row(0, 0, 0, 0, 0, 0, 16'h0900, 1'b1));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_X, 0));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Y, 0));
		plan.push_back(cfg_row(rbnh_pkg::CFG_ORIGIN_Z, 0));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_X, 0));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_Y, 0));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_Z, 0));
		plan.push_back(box_row(100 * ONE, 100 * ONE, 100 * ONE, 200 * ONE, 200 * ONE, 200 * ONE,
			16'h0000, 1'b0));
		plan.push_back(box_row(rbnh_pkg::MINV, rbnh_pkg::MINV, rbnh_pkg::MINV,
			rbnh_pkg::MAXV, rbnh_pkg::MAXV, rbnh_pkg::MAXV, 16'hFFFF, 1'b1));
		plan.push_back(cfg_row(rbnh_pkg::CFG_INV_DIR_X, ONE));
		plan.push_back(cfg_row(CFG_UNMAPPED_LO, 32'sh7FFF0000));
		plan.push_back(cfg_row(CFG_UNMAPPED_HI, rbnh_pkg::MINV));
		plan.push_back(box_row(-ONE, 0, 0, 2 * ONE, 0, 0, 16'h0C00, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_box = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (prev_box) settle();
				write_reg(plan[i].reg_index, plan[i].reg_data);
				prev_box = 1'b0;
			end else begin
				cfg_ch.valid <= 1'b0;
				send_box(plan[i].beat, plan[i].typed, plan[i].want);
				prev_box = 1'b1;
			end
		end
		settle();

		sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			load_ray(p);
			if (p == 3) begin
				// stall the result side long enough to back the pipe up to the input
				hold_asks++;
				no_gaps = 1'b1;
				repeat (6) send_list($urandom_range(1, 4), sent);
				no_gaps = 1'b0;
			end
			while (sent < (p + 1) * RANDOM_BOXES / PHASES) send_list(pick_list_len(), sent);
			settle();
		end

		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> ray_box_nearest_hit.f
src/rbnh_pkg.sv
src/rbnh_if.sv
src/rbnh_slab.sv
src/rbnh_nearest.sv
src/ray_box_nearest_hit.sv
dv/ray_box_nearest_hit_tb.sv
